@@ hdl/assert_macros.svh @@
// assertion macros shared by the weighted choice table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge outside reset
`define WCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define WCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define WCT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WCT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/wct_pkg.sv @@
// shared types and constants of the weighted choice table
package wct_pkg;

  localparam int KEY_BITS       = 6;
  localparam int KEY_RANGE      = 64;
  localparam int IN_WEIGHT_BITS = 16;
  localparam int TOTAL_BITS     = 22;

  // slave-side tdata layout
  localparam int IN_KEY_LSB     = 0;
  localparam int IN_WEIGHT_LSB  = IN_KEY_LSB + KEY_BITS;
  localparam int IN_DRAW_LSB    = IN_WEIGHT_LSB + IN_WEIGHT_BITS;
  localparam int IN_USED_BITS   = IN_DRAW_LSB + TOTAL_BITS;
  localparam int IN_TDATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

  // master-side tdata layout
  localparam int OUT_USED_BITS  = 1 + KEY_BITS + TOTAL_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_USED_BITS;

  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_PICK = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t                op;
    logic [TOTAL_BITS-1:0]  a;
    logic [TOTAL_BITS-1:0]  b;
    logic [TOTAL_BITS-1:0]  limit;
  } alu_req_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0]  result;
    logic                   reached;
  } alu_rsp_t;

endpackage

@@ hdl/weighted_choice_table.sv @@
// weighted choice table top level: sequencer, total register and scan
//
//  channel  | dir | fields
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tuser: kind; tdata: key_id, new_weight, draw
//  m_axis   | out | tdata: picked, chosen_key, total_after
//
// after reset the weight memory is cleared, one entry a cycle, with s_axis_tready
// low. a set beat reads the memory, subtracts the old weight, then adds the new
// weight and writes it back before its result is ready. a pick beat scans at most
// min(NUM_KEYS, 64) keys after a first memory read, its length set by
// the single adder accumulating one memory word per cycle. a pick that cannot
// hit (empty table, zero draw, draw above total) and a set to a key out of range
// skip to the done state. the result waits in the output register while the next
// beat is accepted; a stalled output holds the sequencer before its next result.
module weighted_choice_table #(
  parameter int NUM_KEYS    = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // key_id [5:0], new_weight [21:6], draw [43:22], zero fill above
  input  logic [wct_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // kind: 0 set a weight, 1 pick
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // picked [0], chosen_key [6:1], total_after [28:7], zero fill above
  output logic [wct_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

`include "assert_macros.svh"

  localparam int KW = $clog2(NUM_KEYS);
  // stored weight width: input weight truncated to WEIGHT_BITS
  localparam int EW = (WEIGHT_BITS < wct_pkg::IN_WEIGHT_BITS) ?
                      WEIGHT_BITS : wct_pkg::IN_WEIGHT_BITS;
  // only keys reachable by key_id can ever be non-zero
  localparam int SCAN_KEYS = (NUM_KEYS < wct_pkg::KEY_RANGE) ?
                             NUM_KEYS : wct_pkg::KEY_RANGE;
  localparam int TB = wct_pkg::TOTAL_BITS;
  localparam logic [KW-1:0] LAST_KEY  = KW'(SCAN_KEYS - 1);
  localparam logic [KW-1:0] LAST_ADDR = KW'(NUM_KEYS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_SUB,
    ST_SET_ADD,
    ST_PICK_RD,
    ST_PICK_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  // input beat fields
  logic [wct_pkg::KEY_BITS-1:0]       in_key;
  logic [wct_pkg::IN_WEIGHT_BITS-1:0] in_weight;
  logic [TB-1:0]                      in_draw;

  assign in_key    = s_axis_tdata[wct_pkg::IN_KEY_LSB +: wct_pkg::KEY_BITS];
  assign in_weight = s_axis_tdata[wct_pkg::IN_WEIGHT_LSB +: wct_pkg::IN_WEIGHT_BITS];
  assign in_draw   = s_axis_tdata[wct_pkg::IN_DRAW_LSB +: TB];

  // working registers
  logic [KW-1:0] clr_cnt;
  logic [KW-1:0] raddr;
  logic [KW-1:0] key_idx;
  logic [KW-1:0] key_r;
  logic [EW-1:0] wgt_r;
  logic [TB-1:0] draw_r;
  logic [TB-1:0] sum;
  logic [TB-1:0] acc;
  logic [TB-1:0] total;
  logic          pend_picked;
  logic [KW-1:0] pend_key;

  // output register
  logic                         out_picked;
  logic [wct_pkg::KEY_BITS-1:0] out_key;
  logic [TB-1:0]                out_total;

  // weight memory
  logic          mem_we;
  logic [KW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] rdata;
  logic [TB-1:0] rdata_ext;
  logic [TB-1:0] wgt_ext;

  assign mem_we    = (state == ST_CLEAR) || (state == ST_SET_ADD);
  assign mem_waddr = (state == ST_CLEAR) ? clr_cnt : key_r;
  assign mem_wdata = (state == ST_CLEAR) ? '0 : wgt_r;

  wct_wmem #(
    .DEPTH (NUM_KEYS),
    .WIDTH (EW)
  ) u_wmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rdata_ext = {{(TB-EW){1'b0}}, rdata};
  assign wgt_ext   = {{(TB-EW){1'b0}}, wgt_r};

  // shared arithmetic: total - old, partial + new, running sum + weight
  wct_pkg::alu_req_t alu_req;
  wct_pkg::alu_rsp_t alu_rsp;

  always_comb begin
    alu_req.limit = draw_r;
    case (state)
      ST_SET_SUB: begin
        alu_req.op = wct_pkg::ALU_SUB;
        alu_req.a  = total;
        alu_req.b  = rdata_ext;
      end
      ST_SET_ADD: begin
        alu_req.op = wct_pkg::ALU_ADD;
        alu_req.a  = acc;
        alu_req.b  = wgt_ext;
      end
      default: begin
        alu_req.op = wct_pkg::ALU_ADD;
        alu_req.a  = sum;
        alu_req.b  = rdata_ext;
      end
    endcase
  end

  wct_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // first non-empty key whose running sum reaches the draw
  logic scan_hit;
  assign scan_hit = (rdata != '0) && alu_rsp.reached;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {{wct_pkg::OUT_PAD_BITS{1'b0}}, out_total, out_key, out_picked};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      total         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            key_r       <= KW'(in_key);
            wgt_r       <= in_weight[EW-1:0];
            draw_r      <= in_draw;
            sum         <= '0;
            key_idx     <= '0;
            pend_picked <= 1'b0;
            pend_key    <= '0;
            if (s_axis_tuser == wct_pkg::KIND_SET) begin
              if (int'(in_key) < SCAN_KEYS) begin
                raddr <= KW'(in_key);
                state <= ST_SET_RD;
              end else begin
                state <= ST_DONE;
              end
            end else begin
              if ((total != '0) && (in_draw != '0) && (in_draw <= total)) begin
                raddr <= '0;
                state <= ST_PICK_RD;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_SET_RD: begin
          state <= ST_SET_SUB;
        end
        ST_SET_SUB: begin
          acc   <= alu_rsp.result;
          state <= ST_SET_ADD;
        end
        ST_SET_ADD: begin
          total <= alu_rsp.result;
          state <= ST_DONE;
        end
        ST_PICK_RD: begin
          raddr <= raddr + 1'b1;
          state <= ST_PICK_SCAN;
        end
        ST_PICK_SCAN: begin
          raddr   <= raddr + 1'b1;
          sum     <= alu_rsp.result;
          key_idx <= key_idx + 1'b1;
          if (scan_hit) begin
            pend_picked <= 1'b1;
            pend_key    <= key_idx;
            state       <= ST_DONE;
          end else if (key_idx == LAST_KEY) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_picked    <= pend_picked;
            out_key       <= wct_pkg::KEY_BITS'(pend_key);
            out_total     <= total;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // the running sum stays below the draw until the scan stops
  `WCT_ASSERT_IMPL(a_sum_below_draw, clk, rst, state == ST_PICK_SCAN, sum < draw_r)

  // a draw within the total always hits by the last reachable key
  `WCT_ASSERT_IMPL(a_scan_hits, clk, rst,
                   (state == ST_PICK_SCAN) && (key_idx == LAST_KEY), scan_hit)

  // a finished result waits while the output register is still held
  `WCT_ASSERT_NEXT(a_done_holds, clk, rst,
                   (state == ST_DONE) && m_axis_tvalid && !m_axis_tready,
                   state == ST_DONE)

endmodule

@@ hdl/wct_alu.sv @@
// shared add/subtract unit with a limit compare on the result
module wct_alu (
  input  wct_pkg::alu_req_t req,
  output wct_pkg::alu_rsp_t rsp
);

  logic [wct_pkg::TOTAL_BITS-1:0] result;

  always_comb begin
    case (req.op)
      wct_pkg::ALU_ADD: result = req.a + req.b;
      wct_pkg::ALU_SUB: result = req.a - req.b;
      default:          result = req.a;
    endcase
  end

  assign rsp.result  = result;
  assign rsp.reached = (req.limit <= result);

endmodule

@@ hdl/wct_wmem.sv @@
// weight memory, one write port and one registered read port
module wct_wmem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ dv/tb.sv @@
// testbench for the weighted choice table: directed table, random beats, self-checking predictor
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_BEATS  = 640;
  localparam int FILL_FIRST    = 300;
  localparam int CALM_FIRST    = 150;
  localparam int CALM_LAST     = 250;
  localparam int SQUEEZE_AT    = 120;
  localparam int SQUEEZE_LEN   = 400;

  typedef struct packed {
    logic                               kind;
    logic [wct_pkg::KEY_BITS-1:0]       key;
    logic [wct_pkg::IN_WEIGHT_BITS-1:0] weight;
    logic [wct_pkg::TOTAL_BITS-1:0]     draw;
  } beat_t;

  typedef struct packed {
    logic                           picked;
    logic [wct_pkg::KEY_BITS-1:0]   key;
    logic [wct_pkg::TOTAL_BITS-1:0] total;
  } choice_t;

  typedef struct packed {
    beat_t   b;
    logic    typed;   // expected result written out in the row
    choice_t res;
  } row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [wct_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
  logic                               s_axis_tuser = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [wct_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;

  weighted_choice_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("FAIL weighted_choice_table");
    $finish;
  end

  // predictor state: one weight per key and the running sum
  logic [wct_pkg::IN_WEIGHT_BITS-1:0] key_weight [wct_pkg::KEY_RANGE];
  logic [wct_pkg::TOTAL_BITS-1:0]     weight_sum;
  choice_t                            choice_q[$];

  int  errors = 0;
  int  n_set = 0;
  int  n_pick = 0;
  int  n_hit = 0;
  int  n_checked = 0;
  int  peak_sum = 0;
  bit  calm = 1'b0;

  // roulette-wheel outcome of one beat, state updated as the block would
  function automatic choice_t predict_choice(beat_t b);
    choice_t     c;
    int unsigned acc;
    c = '0;
    if (b.kind == wct_pkg::KIND_SET) begin
      weight_sum      = weight_sum - key_weight[b.key] + b.weight;
      key_weight[b.key] = b.weight;
      n_set++;
    end else begin
      n_pick++;
      if (weight_sum != 0 && b.draw != 0 && b.draw <= weight_sum) begin
        acc = 0;
        for (int k = 0; k < wct_pkg::KEY_RANGE; k++) begin
          acc += key_weight[k];
          if (!c.picked && key_weight[k] != 0 && b.draw <= acc) begin
            c.picked = 1'b1;
            c.key    = k[wct_pkg::KEY_BITS-1:0];
          end
        end
        if (c.picked) n_hit++;
      end
    end
    if (int'(weight_sum) > peak_sum) peak_sum = int'(weight_sum);
    c.total = weight_sum;
    return c;
  endfunction

  function automatic row_t row(logic kind, int key, int weight, int draw, logic typed = 1'b0,
                               logic picked = 1'b0, int ckey = 0, int total = 0);
    row_t r;
    r.b.kind   = kind;
    r.b.key    = key[wct_pkg::KEY_BITS-1:0];
    r.b.weight = weight[wct_pkg::IN_WEIGHT_BITS-1:0];
    r.b.draw   = draw[wct_pkg::TOTAL_BITS-1:0];
    r.typed    = typed;
    r.res.picked = picked;
    r.res.key    = ckey[wct_pkg::KEY_BITS-1:0];
    r.res.total  = total[wct_pkg::TOTAL_BITS-1:0];
    return r;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 96) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  // drive one beat at the falling edge, hold it until accepted
  task automatic offer(input beat_t b, input logic typed, input choice_t typed_res);
    logic [wct_pkg::IN_TDATA_BITS-1:0] data;
    choice_t                           want;
    data = '0;
    data[wct_pkg::IN_KEY_LSB +: wct_pkg::KEY_BITS]          = b.key;
    data[wct_pkg::IN_WEIGHT_LSB +: wct_pkg::IN_WEIGHT_BITS] = b.weight;
    data[wct_pkg::IN_DRAW_LSB +: wct_pkg::TOTAL_BITS]       = b.draw;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.kind;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    want = predict_choice(b);
    if (typed) want = typed_res;
    choice_q = {choice_q, want};
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // receiver readiness: random stalls, one long hold-off, calm stretch
  initial begin
    int  idle_left;
    bit  squeezed;
    idle_left = 0;
    squeezed  = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeezed && n_checked >= SQUEEZE_AT) begin
        // long hold-off while the sender keeps offering, so the block backs up
        squeezed = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_LEN - 1) @(negedge clk);
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else if (idle_left > 0) begin
        m_axis_tready <= 1'b0;
        idle_left--;
      end else begin
        idle_left = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
        m_axis_tready <= (idle_left == 0);
        if (idle_left > 0) idle_left--;
      end
    end
  end

  // result checker, field by field against the oldest expectation
  initial begin
    choice_t got;
    choice_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.picked = m_axis_tdata[0];
        got.key    = m_axis_tdata[wct_pkg::KEY_BITS:1];
        got.total  = m_axis_tdata[wct_pkg::KEY_BITS+1 +: wct_pkg::TOTAL_BITS];
        if (choice_q.size() == 0) begin
          $error("result beat with nothing expected: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = choice_q.pop_front();
          n_checked++;
          if (got.picked !== want.picked) begin
            $error("picked: expected %0d, got %0d", want.picked, got.picked);
            errors++;
          end
          if (got.key !== want.key) begin
            $error("chosen_key: expected %0d, got %0d", want.key, got.key);
            errors++;
          end
          if (got.total !== want.total) begin
            $error("total_after: expected %0d, got %0d", want.total, got.total);
            errors++;
          end
          if (m_axis_tdata[wct_pkg::OUT_TDATA_BITS-1:wct_pkg::OUT_USED_BITS] !== '0) begin
            $error("fill: expected 0, got %h",
                   m_axis_tdata[wct_pkg::OUT_TDATA_BITS-1:wct_pkg::OUT_USED_BITS]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    row_t    rows[$];
    beat_t   b;
    int      r;
    int      gap;
    for (int k = 0; k < wct_pkg::KEY_RANGE; k++) key_weight[k] = '0;
    weight_sum = '0;

    // directed: empty table, extreme weights and draws, removal, re-set
    rows = '{
      row(wct_pkg::KIND_PICK, 0, 0, 1, 1'b1, 1'b0, 0, 0),          // pick on empty table
      row(wct_pkg::KIND_PICK, 63, 16'hffff, 0, 1'b1, 1'b0, 0, 0),  // zero draw, empty
      row(wct_pkg::KIND_SET, 0, 65535, 0, 1'b1, 1'b0, 0, 65535),   // lowest key, max weight
      row(wct_pkg::KIND_SET, 63, 1, 22'h3fffff, 1'b1, 1'b0, 0, 65536), // highest key, min
      row(wct_pkg::KIND_PICK, 0, 0, 0, 1'b1, 1'b0, 0, 65536),      // zero draw
      row(wct_pkg::KIND_PICK, 0, 0, 1, 1'b1, 1'b1, 0, 65536),      // smallest draw
      row(wct_pkg::KIND_PICK, 0, 0, 65535, 1'b1, 1'b1, 0, 65536),  // draw at first boundary
      row(wct_pkg::KIND_PICK, 0, 0, 65536, 1'b1, 1'b1, 63, 65536), // draw equal to total
      row(wct_pkg::KIND_PICK, 0, 0, 65537, 1'b1, 1'b0, 0, 65536),  // draw just above total
      row(wct_pkg::KIND_PICK, 63, 65535, 22'h3fffff, 1'b1, 1'b0, 0, 65536), // largest draw
      row(wct_pkg::KIND_SET, 31, 16'h5555, 22'h2aaaaa),
      row(wct_pkg::KIND_SET, 32, 16'haaaa, 22'h155555),
      row(wct_pkg::KIND_PICK, 21, 16'h1234, 87381),
      row(wct_pkg::KIND_PICK, 42, 16'h4321, 87382),
      row(wct_pkg::KIND_PICK, 0, 0, 131071),
      row(wct_pkg::KIND_SET, 0, 0, 0, 1'b1, 1'b0, 0, 65536),       // remove a key
      row(wct_pkg::KIND_PICK, 0, 0, 1),
      row(wct_pkg::KIND_SET, 31, 0, 0),
      row(wct_pkg::KIND_SET, 32, 0, 0),
      row(wct_pkg::KIND_PICK, 0, 0, 1, 1'b1, 1'b1, 63, 1),         // only one key left
      row(wct_pkg::KIND_SET, 63, 0, 0, 1'b1, 1'b0, 0, 0),          // table emptied again
      row(wct_pkg::KIND_PICK, 0, 0, 1, 1'b1, 1'b0, 0, 0),
      row(wct_pkg::KIND_SET, 5, 7, 0),
      row(wct_pkg::KIND_SET, 5, 7, 0),                             // same weight again
      row(wct_pkg::KIND_PICK, 0, 0, 7)
    };

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      offer(rows[i].b, rows[i].typed, rows[i].res);
      pause(($urandom_range(0, 1) == 0) ? 0 : idle_len());
    end

    // random: sets and picks, picks mostly inside the total, plus a burst filling every key
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      calm = (i >= CALM_FIRST && i < CALM_LAST);
      b.key    = wct_pkg::KEY_BITS'($urandom_range(0, wct_pkg::KEY_RANGE - 1));
      b.weight = wct_pkg::IN_WEIGHT_BITS'($urandom());
      b.draw   = wct_pkg::TOTAL_BITS'($urandom());
      r = $urandom_range(0, 99);
      if (i >= FILL_FIRST && i < FILL_FIRST + wct_pkg::KEY_RANGE) begin
        b.kind   = wct_pkg::KIND_SET;
        b.key    = wct_pkg::KEY_BITS'(i - FILL_FIRST);
        b.weight = '1;
      end else if (r < 45) begin
        b.kind = wct_pkg::KIND_SET;
        r = $urandom_range(0, 99);
        if (r < 10) b.weight = '0;
        else if (r < 25) b.weight = '1;
        else if (r < 50) b.weight = wct_pkg::IN_WEIGHT_BITS'($urandom_range(1, 15));
      end else begin
        b.kind = wct_pkg::KIND_PICK;
        r = $urandom_range(0, 99);
        if (r < 75) begin
          b.draw = (weight_sum != 0) ?
                   wct_pkg::TOTAL_BITS'($urandom_range(1, weight_sum)) : 1;
        end else if (r < 83) begin
          b.draw = '0;
        end else if (r < 91) begin
          b.draw = wct_pkg::TOTAL_BITS'(weight_sum + $urandom_range(1, 1000));
        end else if (r < 95) begin
          b.draw = weight_sum;
        end
      end
      offer(b, 1'b0, '0);
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      pause(gap);
    end
    calm = 1'b0;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (choice_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d weight updates and %0d picks, %0d of which chose a key",
             n_set, n_pick, n_hit);
    $display("%0d results compared, running total peaked at %0d", n_checked, peak_sum);
    if (errors == 0) begin
      $display("PASS weighted_choice_table");
    end else begin
      $display("FAIL weighted_choice_table");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/wct_pkg.sv
hdl/wct_alu.sv
hdl/wct_wmem.sv
hdl/weighted_choice_table.sv
dv/tb.sv
